// File: sv/itsm_pkg.sv
// Shared constants and helper functions of the IMU tilt and shock monitor.
// Used by the top level and by its port checker; depends on nothing else.
package itsm_pkg;

  localparam int unsigned IN_W = 128;
  localparam int unsigned OUT_W = 240;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_G_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_HOLD = 2'd2;

  localparam logic [15:0] G_THRESHOLD_RST = 16'd3000;
  localparam logic [15:0] ROT_THRESHOLD_RST = 16'd16000;
  localparam logic [15:0] ALERT_HOLD_RST = 16'd500;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ITER_W = 5;
  localparam int signed ANG_LIMIT = 46080;
  localparam logic signed [25:0] Z_HALF_TURN = 26'sd11796480;
  localparam logic [11:0] BLEND_DIV = 12'd2500;
  localparam logic [27:0] BLEND_ROUND = 28'd1250;

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic signed [25:0] atan_q16(input logic [ITER_W-1:0] idx);
    logic signed [25:0] v;
    unique case (idx)
      5'd0: v = 26'sd2949120;
      5'd1: v = 26'sd1740967;
      5'd2: v = 26'sd919879;
      5'd3: v = 26'sd466945;
      5'd4: v = 26'sd234379;
      5'd5: v = 26'sd117304;
      5'd6: v = 26'sd58666;
      5'd7: v = 26'sd29335;
      5'd8: v = 26'sd14668;
      5'd9: v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  // Saturates an angle to plus or minus 180 degrees in Q8.
  function automatic logic signed [16:0] clamp_ang(input logic signed [25:0] v);
    logic signed [16:0] r;
    if (v > 26'sd46080) begin
      r = 17'sd46080;
    end else if (v < -26'sd46080) begin
      r = -17'sd46080;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

// File: sv/imu_tilt_and_shock_monitor_top.sv
// Top level of the IMU tilt and shock monitor: squares, bit-serial roots,
// iterative CORDIC, serial blend divider and result register. Uses itsm_pkg.
//
// One sample is taken at a time. From its transfer on the input stream to its
// result being offered it passes through squaring, three 24-bit square roots
// at one result bit a cycle, the pitch and roll arctangents, the two filter
// divisions by 2500 at one quotient bit a cycle (skipped on the first sample)
// and a final result state; a new sample is taken only once the result is
// registered. The next sample may be taken while a result still waits.
module imu_tilt_and_shock_monitor_top #(
  parameter int unsigned CORDIC_STEPS = itsm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itsm_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [itsm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, timestamp_ms
  input  logic [itsm_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pitch_deg, roll_deg, accel_magnitude, rotation_magnitude, accel_peak,
  // rotation_peak, jerk_rate, lateral_g, longitudinal_g, yaw_travel_sum,
  // alert_sustained, alert_elapsed_ms, zero fill
  output logic [itsm_pkg::OUT_W-1:0]     m_axis_tdata
);

  localparam int unsigned IW = itsm_pkg::ITER_W;
  localparam logic [IW-1:0] LastStep = IW'(CORDIC_STEPS - 1);
  localparam logic [IW-1:0] LastRoot = IW'(23);
  localparam logic [IW-1:0] LastDiv = IW'(27);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQR   = 10'b0000000010,
    S_ROOT  = 10'b0000000100,
    S_CINIT = 10'b0000001000,
    S_CROT  = 10'b0000010000,
    S_CEND  = 10'b0000100000,
    S_BMUL  = 10'b0001000000,
    S_BDIV  = 10'b0010000000,
    S_BEND  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] g_thr_q, rot_thr_q, hold_q;

  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic [31:0] ts_q;

  logic [3:0] sq_cnt_q;
  logic [2:0] pidx_q;
  logic signed [16:0] sq_op;
  logic signed [33:0] sq_full;
  logic [31:0] prod_q, asq_q, axz_q, gsq_q;
  logic trig_a_q, trig_g_q;

  logic [IW-1:0] it_q;
  logic [1:0] rsel_q;
  logic [47:0] rad_q;
  logic [23:0] root_q, root_d;
  logic [25:0] rem_q, rem_d;
  logic [27:0] rem_sh, trial;
  logic root_ge;
  logic [15:0] amag_q, gmag_q;
  logic [23:0] px_q;

  logic asel_q, czero_q;
  logic signed [26:0] cx_q, cy_q, x0, y0, xs, ys, ax_ext;
  logic signed [25:0] cz_q, zr;
  logic signed [16:0] pa_q, ra_q, ang;

  logic bsel_q, neg_q;
  logic signed [29:0] est_ext, g_ext, acc_ext, num;
  logic [27:0] dv_q;
  logic [11:0] drem_q;
  logic [12:0] dsh;
  logic div_ge;
  logic signed [25:0] qs;

  logic signed [16:0] pitch_est_q, roll_est_q;
  logic seeded_q, in_alert_q;
  logic [15:0] prev_mag_q, peak_a_q, peak_g_q;
  logic [22:0] last_jerk_q;
  logic [47:0] yaw_q;
  logic [31:0] alert_start_q;

  logic m_valid_q;
  logic [itsm_pkg::OUT_W-1:0] m_data_q;

  logic fin_go;
  logic [15:0] pk_a, pk_g, dmag, abs_gz;
  logic [22:0] jerk_new, jerk_out;
  logic [48:0] yaw_sum;
  logic [47:0] yaw_new, yaw_out;
  logic [31:0] elapsed, elapsed_out;
  logic trig, sust_out;
  logic signed [16:0] pitch_out, roll_out;
  logic [15:0] lat_out, lon_out;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;
  assign fin_go = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  // Squarer operand.
  always_comb begin
    unique case (sq_cnt_q[2:0])
      3'd0: sq_op = 17'(ax_q);
      3'd1: sq_op = 17'(ay_q);
      3'd2: sq_op = 17'(az_q);
      3'd3: sq_op = 17'(gx_q);
      3'd4: sq_op = 17'(gy_q);
      3'd5: sq_op = 17'(gz_q);
      3'd6: sq_op = $signed({1'b0, g_thr_q});
      default: sq_op = $signed({1'b0, rot_thr_q});
    endcase
    sq_full = sq_op * sq_op;
  end

  // One result bit of the square root per cycle.
  always_comb begin
    rem_sh = {rem_q, rad_q[47:46]};
    trial = {2'b00, root_q, 2'b01};
    root_ge = (rem_sh >= trial);
    rem_d = root_ge ? 26'(rem_sh - trial) : rem_sh[25:0];
    root_d = {root_q[22:0], root_ge};
  end

  // CORDIC start vector and one vectoring step.
  always_comb begin
    ax_ext = $signed({{3{ax_q[15]}}, ax_q, 8'h00});
    if (!asel_q) begin
      y0 = $signed({{3{ay_q[15]}}, ay_q, 8'h00});
      x0 = $signed({3'b000, px_q});
    end else begin
      y0 = -ax_ext;
      x0 = $signed({{3{az_q[15]}}, az_q, 8'h00});
    end
    xs = cx_q >>> it_q;
    ys = cy_q >>> it_q;
    zr = (cz_q + 26'sd128) >>> 8;
    ang = czero_q ? 17'sd0 : itsm_pkg::clamp_ang(zr);
  end

  // Filter numerator and one quotient bit of the divide by 2500.
  always_comb begin
    est_ext = bsel_q ? 30'(roll_est_q) : 30'(pitch_est_q);
    g_ext = bsel_q ? 30'(gy_q) : 30'(gx_q);
    acc_ext = bsel_q ? 30'(ra_q) : 30'(pa_q);
    num = est_ext * 30'sd2450 + g_ext * 30'sd392 + acc_ext * 30'sd50;
    dsh = {drem_q, dv_q[27]};
    div_ge = (dsh >= {1'b0, itsm_pkg::BLEND_DIV});
    qs = neg_q ? -$signed({9'd0, dv_q[16:0]}) : $signed({9'd0, dv_q[16:0]});
  end

  // Result of one sample.
  always_comb begin
    pk_a = (amag_q > peak_a_q) ? amag_q : peak_a_q;
    pk_g = (gmag_q > peak_g_q) ? gmag_q : peak_g_q;
    dmag = (amag_q > prev_mag_q) ? (amag_q - prev_mag_q) : (prev_mag_q - amag_q);
    jerk_new = 23'(dmag) * 23'd100;
    abs_gz = gz_q[15] ? 16'(-gz_q) : 16'(gz_q);
    yaw_sum = {1'b0, yaw_q} + {33'd0, abs_gz};
    yaw_new = yaw_sum[48] ? {48{1'b1}} : yaw_sum[47:0];
    elapsed = ts_q - alert_start_q;
    trig = trig_a_q || trig_g_q;
    if (seeded_q) begin
      pitch_out = pitch_est_q;
      roll_out = roll_est_q;
      jerk_out = jerk_new;
      yaw_out = yaw_new;
      lat_out = ay_q;
      lon_out = ax_q;
    end else begin
      pitch_out = pa_q;
      roll_out = ra_q;
      jerk_out = last_jerk_q;
      yaw_out = yaw_q;
      lat_out = 16'd0;
      lon_out = 16'd0;
    end
    if (trig && in_alert_q) begin
      elapsed_out = elapsed;
      sust_out = (elapsed >= {16'd0, hold_q});
    end else begin
      elapsed_out = 32'd0;
      sust_out = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_SQR;
      S_SQR: if (sq_cnt_q == 4'd8) state_d = S_ROOT;
      S_ROOT: if (it_q == LastRoot && rsel_q == 2'd2) state_d = S_CINIT;
      S_CINIT: state_d = S_CROT;
      S_CROT: if (it_q == LastStep) state_d = S_CEND;
      S_CEND: begin
        if (!asel_q) begin
          state_d = S_CINIT;
        end else begin
          state_d = seeded_q ? S_BMUL : S_FIN;
        end
      end
      S_BMUL: state_d = S_BDIV;
      S_BDIV: if (it_q == LastDiv) state_d = S_BEND;
      S_BEND: state_d = bsel_q ? S_FIN : S_BMUL;
      S_FIN: if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      g_thr_q <= itsm_pkg::G_THRESHOLD_RST;
      rot_thr_q <= itsm_pkg::ROT_THRESHOLD_RST;
      hold_q <= itsm_pkg::ALERT_HOLD_RST;
      pitch_est_q <= '0;
      roll_est_q <= '0;
      seeded_q <= 1'b0;
      in_alert_q <= 1'b0;
      prev_mag_q <= '0;
      peak_a_q <= '0;
      peak_g_q <= '0;
      last_jerk_q <= '0;
      yaw_q <= '0;
      alert_start_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          itsm_pkg::CFG_G_THRESHOLD: g_thr_q <= cfg_wdata_i;
          itsm_pkg::CFG_ROT_THRESHOLD: rot_thr_q <= cfg_wdata_i;
          itsm_pkg::CFG_ALERT_HOLD: hold_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == S_BEND) begin
        if (bsel_q) begin
          roll_est_q <= itsm_pkg::clamp_ang(qs);
        end else begin
          pitch_est_q <= itsm_pkg::clamp_ang(qs);
        end
      end
      if (fin_go) begin
        m_valid_q <= 1'b1;
        peak_a_q <= pk_a;
        peak_g_q <= pk_g;
        prev_mag_q <= amag_q;
        if (!seeded_q) begin
          seeded_q <= 1'b1;
          pitch_est_q <= pa_q;
          roll_est_q <= ra_q;
        end else begin
          last_jerk_q <= jerk_new;
          yaw_q <= yaw_new;
        end
        if (trig) begin
          if (!in_alert_q) begin
            in_alert_q <= 1'b1;
            alert_start_q <= ts_q;
          end
        end else begin
          in_alert_q <= 1'b0;
          alert_start_q <= '0;
        end
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        {ts_q, gz_q, gy_q, gx_q, az_q, ay_q, ax_q} <= s_axis_tdata;
        sq_cnt_q <= 4'd0;
      end
      S_SQR: begin
        sq_cnt_q <= sq_cnt_q + 4'd1;
        pidx_q <= sq_cnt_q[2:0];
        prod_q <= sq_full[31:0];
        if (sq_cnt_q != 4'd0) begin
          unique case (pidx_q)
            3'd0: begin asq_q <= prod_q; axz_q <= prod_q; end
            3'd1: asq_q <= asq_q + prod_q;
            3'd2: begin asq_q <= asq_q + prod_q; axz_q <= axz_q + prod_q; end
            3'd3: gsq_q <= prod_q;
            3'd4: gsq_q <= gsq_q + prod_q;
            3'd5: gsq_q <= gsq_q + prod_q;
            3'd6: trig_a_q <= (asq_q > prod_q);
            default: trig_g_q <= (gsq_q > prod_q);
          endcase
        end
        rad_q <= {16'd0, asq_q};
        root_q <= '0;
        rem_q <= '0;
        it_q <= '0;
        rsel_q <= 2'd0;
      end
      S_ROOT: begin
        if (it_q == LastRoot) begin
          it_q <= '0;
          root_q <= '0;
          rem_q <= '0;
          rsel_q <= rsel_q + 2'd1;
          rad_q <= (rsel_q == 2'd0) ? {16'd0, gsq_q} : {axz_q, 16'd0};
          unique case (rsel_q)
            2'd0: amag_q <= root_d[15:0];
            2'd1: gmag_q <= root_d[15:0];
            default: px_q <= root_d;
          endcase
        end else begin
          it_q <= it_q + IW'(1);
          root_q <= root_d;
          rem_q <= rem_d;
          rad_q <= {rad_q[45:0], 2'b00};
        end
        asel_q <= 1'b0;
      end
      S_CINIT: begin
        it_q <= '0;
        czero_q <= (x0 == 27'sd0) && (y0 == 27'sd0);
        if (x0 < 27'sd0) begin
          cx_q <= -x0;
          cy_q <= -y0;
          cz_q <= (y0 >= 27'sd0) ? itsm_pkg::Z_HALF_TURN : -itsm_pkg::Z_HALF_TURN;
        end else begin
          cx_q <= x0;
          cy_q <= y0;
          cz_q <= 26'sd0;
        end
      end
      S_CROT: begin
        it_q <= it_q + IW'(1);
        if (!cy_q[26]) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + itsm_pkg::atan_q16(it_q);
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - itsm_pkg::atan_q16(it_q);
        end
      end
      S_CEND: begin
        if (asel_q) begin
          ra_q <= ang;
        end else begin
          pa_q <= ang;
        end
        asel_q <= 1'b1;
        bsel_q <= 1'b0;
      end
      S_BMUL: begin
        it_q <= '0;
        drem_q <= '0;
        neg_q <= num[29];
        dv_q <= (num[29] ? 28'(-num) : 28'(num)) + itsm_pkg::BLEND_ROUND;
      end
      S_BDIV: begin
        it_q <= it_q + IW'(1);
        drem_q <= div_ge ? 12'(dsh - {1'b0, itsm_pkg::BLEND_DIV}) : dsh[11:0];
        dv_q <= {dv_q[26:0], div_ge};
      end
      S_BEND: bsel_q <= 1'b1;
      S_FIN: begin
        if (fin_go) begin
          m_data_q <= {6'd0, elapsed_out, sust_out, yaw_out, lon_out, lat_out,
                       jerk_out, pk_g, pk_a, gmag_q, amag_q, roll_out, pitch_out};
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/itsm_checker.sv
// Port checker of the IMU tilt and shock monitor and its bind to the top level.
// Uses itsm_pkg; sees only the ports of imu_tilt_and_shock_monitor_top.
module itsm_port_assert (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [itsm_pkg::OUT_W-1:0] m_axis_tdata
);

  // A stalled result transfer keeps its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // After a sample transfer the block is busy with it.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while busy");

  // The reported peaks never fall below the current magnitudes.
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[81:66] >= m_axis_tdata[49:34]) &&
                      (m_axis_tdata[97:82] >= m_axis_tdata[65:50]))
    else $error("peak below magnitude");

  // Pitch and roll stay within plus or minus 180 degrees.
  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[16:0]) <= itsm_pkg::ANG_LIMIT) &&
      ($signed(m_axis_tdata[16:0]) >= -itsm_pkg::ANG_LIMIT) &&
      ($signed(m_axis_tdata[33:17]) <= itsm_pkg::ANG_LIMIT) &&
      ($signed(m_axis_tdata[33:17]) >= -itsm_pkg::ANG_LIMIT))
    else $error("angle out of range");

endmodule

bind imu_tilt_and_shock_monitor_top itsm_port_assert u_itsm_port_assert (.*);

// File: dv/itsm_checker.sv
// Stream checker for the IMU tilt and shock monitor: predicts each result
// from the accepted samples and register writes and compares it field by field.
// Depends on itsm_pkg for the port widths and register indexes.
module itsm_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itsm_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [itsm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [itsm_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [itsm_pkg::OUT_W-1:0]     m_axis_tdata,
  output int                             err_count_o,
  output int                             pending_o
);

  typedef struct {
    logic signed [16:0] pitch;
    logic signed [16:0] roll;
    logic [15:0]        amag;
    logic [15:0]        gmag;
    logic [15:0]        apeak;
    logic [15:0]        gpeak;
    logic [22:0]        jerk;
    logic [15:0]        lat;
    logic [15:0]        lon;
    logic [47:0]        yaw;
    logic               sustained;
    logic [31:0]        elapsed;
  } monitor_out_t;

  localparam int NUM_STEPS = 16;
  localparam longint ATAN_DEG_Q16 [NUM_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };
  localparam longint ANGLE_MAX = 46080;
  localparam longint unsigned YAW_TOP = 48'hFFFF_FFFF_FFFF;

  monitor_out_t        expected_q[$];
  longint              pitch_state, roll_state;
  bit                  is_seeded, alert_active;
  longint unsigned     prev_mag, jerk_state, accel_max, rot_max, yaw_total;
  logic [31:0]         alert_begin;
  logic [15:0]         g_limit, rot_limit, hold_ms;
  int                  errors;

  assign err_count_o = errors;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > n) bitpos >>= 2;
    while (bitpos != 0) begin
      if (n >= root + bitpos) begin
        n -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  function automatic longint sat_angle(input longint v);
    if (v > ANGLE_MAX) return ANGLE_MAX;
    if (v < -ANGLE_MAX) return -ANGLE_MAX;
    return v;
  endfunction

  function automatic longint vector_angle(input longint y, input longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NUM_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_DEG_Q16[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_DEG_Q16[i];
      end
    end
    return sat_angle((z + 128) >>> 8);
  endfunction

  function automatic longint fuse_angle(input longint est, input longint rate,
                                        input longint tilt);
    longint num, q;
    num = 2450 * est + 392 * rate + 50 * tilt;
    if (num >= 0) q = (num + 1250) / 2500;
    else q = -((-num + 1250) / 2500);
    return sat_angle(q);
  endfunction

  task automatic predict_sample(input logic [itsm_pkg::IN_W-1:0] d);
    longint ax, ay, az, gx, gy, gz, pa, ra;
    longint unsigned asq, gsq, amag, gmag, diff;
    logic [31:0] ts;
    monitor_out_t r;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    gx = longint'($signed(d[63:48]));
    gy = longint'($signed(d[79:64]));
    gz = longint'($signed(d[95:80]));
    ts = d[127:96];
    asq = ax * ax + ay * ay + az * az;
    gsq = gx * gx + gy * gy + gz * gz;
    amag = int_sqrt(asq);
    gmag = int_sqrt(gsq);
    r.lat = '0;
    r.lon = '0;
    r.sustained = 1'b0;
    r.elapsed = '0;
    if (amag > accel_max) accel_max = amag;
    if (gmag > rot_max) rot_max = gmag;
    pa = vector_angle(ay * 256, longint'(int_sqrt((ax * ax + az * az) << 16)));
    ra = vector_angle(-ax * 256, az * 256);
    if (!is_seeded) begin
      pitch_state = pa;
      roll_state = ra;
      prev_mag = amag;
      is_seeded = 1'b1;
    end else begin
      diff = (amag > prev_mag) ? amag - prev_mag : prev_mag - amag;
      pitch_state = fuse_angle(pitch_state, gx, pa);
      roll_state = fuse_angle(roll_state, gy, ra);
      r.lat = d[31:16];
      r.lon = d[15:0];
      jerk_state = diff * 100;
      prev_mag = amag;
      yaw_total += (gz < 0) ? -gz : gz;
      if (yaw_total > YAW_TOP) yaw_total = YAW_TOP;
    end
    if (asq > longint'(g_limit) * g_limit || gsq > longint'(rot_limit) * rot_limit) begin
      if (!alert_active) begin
        alert_begin = ts;
        alert_active = 1'b1;
      end else begin
        r.elapsed = ts - alert_begin;
        r.sustained = (r.elapsed >= hold_ms);
      end
    end else begin
      alert_active = 1'b0;
      alert_begin = '0;
    end
    r.pitch = pitch_state[16:0];
    r.roll = roll_state[16:0];
    r.amag = amag[15:0];
    r.gmag = gmag[15:0];
    r.apeak = accel_max[15:0];
    r.gpeak = rot_max[15:0];
    r.jerk = jerk_state[22:0];
    r.yaw = yaw_total[47:0];
    expected_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10) begin
        $display("Mismatch in %s: expected %0h, got %0h", name, exp_v, act_v);
      end
    end
  endtask

  task automatic check_result(input logic [itsm_pkg::OUT_W-1:0] d);
    monitor_out_t e;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected result transfer: %0h", d);
      return;
    end
    e = expected_q.pop_front();
    check_field("pitch_deg", 48'(e.pitch[16:0]), 48'(d[16:0]));
    check_field("roll_deg", 48'(e.roll[16:0]), 48'(d[33:17]));
    check_field("accel_magnitude", 48'(e.amag), 48'(d[49:34]));
    check_field("rotation_magnitude", 48'(e.gmag), 48'(d[65:50]));
    check_field("accel_peak", 48'(e.apeak), 48'(d[81:66]));
    check_field("rotation_peak", 48'(e.gpeak), 48'(d[97:82]));
    check_field("jerk_rate", 48'(e.jerk), 48'(d[120:98]));
    check_field("lateral_g", 48'(e.lat), 48'(d[136:121]));
    check_field("longitudinal_g", 48'(e.lon), 48'(d[152:137]));
    check_field("yaw_travel_sum", e.yaw, d[200:153]);
    check_field("alert_sustained", 48'(e.sustained), 48'(d[201]));
    check_field("alert_elapsed_ms", 48'(e.elapsed), 48'(d[233:202]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      pitch_state = 0;
      roll_state = 0;
      is_seeded = 1'b0;
      alert_active = 1'b0;
      prev_mag = 0;
      jerk_state = 0;
      accel_max = 0;
      rot_max = 0;
      yaw_total = 0;
      alert_begin = '0;
      g_limit = itsm_pkg::G_THRESHOLD_RST;
      rot_limit = itsm_pkg::ROT_THRESHOLD_RST;
      hold_ms = itsm_pkg::ALERT_HOLD_RST;
      errors = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          itsm_pkg::CFG_G_THRESHOLD: g_limit = cfg_wdata_i;
          itsm_pkg::CFG_ROT_THRESHOLD: rot_limit = cfg_wdata_i;
          itsm_pkg::CFG_ALERT_HOLD: hold_ms = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      pending_o = expected_q.size();
    end
  end

endmodule

// File: dv/tb.sv
// Top of the IMU tilt and shock monitor testbench: clock, reset, register
// writes, sample stimulus with idle and stall phases, and the verdict.
// Depends on itsm_pkg, imu_tilt_and_shock_monitor_top and itsm_checker.
module tb;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [itsm_pkg::CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [itsm_pkg::CFG_W-1:0]     cfg_wdata_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [itsm_pkg::IN_W-1:0]      s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [itsm_pkg::OUT_W-1:0]     m_axis_tdata;
  int                             err_count, pending;

  int                             send_idle_pct = 0;
  int                             recv_stall_pct = 0;
  int                             hold_off_cycles = 0;
  logic [31:0]                    sample_ts = '0;

  always #10 clk_i = ~clk_i;

  imu_tilt_and_shock_monitor_top DUT (.*);

  itsm_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .err_count_o(err_count), .pending_o(pending)
  );

  // The receiver drops tready at random, or for a long stretch when asked.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_sample(input int ax, input int ay, input int az, input int gx,
                             input int gy, input int gz, input logic [31:0] ts);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ts, gz[15:0], gy[15:0], gx[15:0], az[15:0], ay[15:0], ax[15:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_thresholds(input logic [15:0] g_thr, input logic [15:0] rot_thr,
                                  input logic [15:0] hold);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= itsm_pkg::CFG_G_THRESHOLD;
    cfg_wdata_i <= g_thr;
    @(negedge clk_i);
    cfg_addr_i <= itsm_pkg::CFG_ROT_THRESHOLD;
    cfg_wdata_i <= rot_thr;
    @(negedge clk_i);
    cfg_addr_i <= itsm_pkg::CFG_ALERT_HOLD;
    cfg_wdata_i <= hold;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int near_value(input int center, input int spread);
    return center + int'($urandom_range(2 * spread)) - spread;
  endfunction

  task automatic random_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      sample_ts = sample_ts + $urandom_range(1, 30);
      send_sample(near_value(0, 3000), near_value(0, 3000), near_value(1000, 3000),
                  near_value(0, 18000), near_value(0, 18000), near_value(0, 18000),
                  sample_ts);
    end else if (sel < 80) begin
      sample_ts = sample_ts + $urandom_range(1, 30);
      send_sample(($urandom_range(1)) ? 32767 : -32768, ($urandom_range(1)) ? 32767 : -32768,
                  ($urandom_range(1)) ? 32767 : -32768, ($urandom_range(1)) ? 32767 : -32768,
                  ($urandom_range(1)) ? 32767 : -32768, ($urandom_range(1)) ? 32767 : -32768,
                  sample_ts);
    end else begin
      sample_ts = $urandom;
      send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, sample_ts);
    end
  endtask

  task automatic random_phase(input int send_pct, input int stall_pct, input int count,
                              input bit squeeze);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    if (squeeze) hold_off_cycles = 3000;
    repeat (count) random_sample();
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples under the reset thresholds; the first one seeds the angles.
    send_sample(0, 0, 1000, 0, 0, 0, 32'd0);
    send_sample(0, 0, 0, 0, 0, 0, 32'd10);
    send_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'd20);
    send_sample(32767, 32767, 32767, 32767, 32767, 32767, 32'd30);
    send_sample(0, 0, -1000, 0, 0, 0, 32'd40);
    send_sample(500, -300, -1000, 16, -16, 0, 32'd50);
    send_sample(-700, 300, -1000, -16, 16, -5, 32'd60);
    send_sample(0, 0, 1000, 0, 0, 0, 32'd70);
    send_sample(5000, 0, 0, 0, 0, 100, 32'd100);
    send_sample(5000, 0, 0, 0, 0, 100, 32'd200);
    send_sample(5000, 0, 0, 0, 0, 100, 32'd600);
    send_sample(0, 5000, 0, 0, 0, -100, 32'd601);
    send_sample(0, 0, 1000, 0, 0, 0, 32'd700);
    send_sample(0, 0, 1000, 20000, 0, 0, 32'd710);
    send_sample(0, 0, 1000, 0, 0, 20000, 32'd720);
    send_sample(0, 0, 1000, 0, 0, 0, 32'd730);
    send_sample(0, 0, 3000, 0, 0, 0, 32'd740);
    send_sample(0, 0, 3001, 0, 0, 0, 32'hFFFF_FFF0);
    send_sample(0, 0, 3001, 0, 0, 0, 32'h0000_0010);
    send_sample(0, 0, 1000, 0, 16000, 0, 32'h0000_0020);
    send_sample(0, 0, 1000, 0, 16001, 0, 32'h0000_0030);
    wait_drained();
    sample_ts = 32'h0000_0040;

    write_thresholds(16'd0, 16'd0, 16'd0);
    random_phase(0, 0, 185, 1'b0);
    write_thresholds(16'd56756, 16'd56756, 16'd65535);
    random_phase(69, 0, 185, 1'b0);
    write_thresholds(16'($urandom_range(500, 6000)), 16'($urandom_range(2000, 30000)),
                     16'($urandom_range(0, 200)));
    random_phase(0, 69, 185, 1'b0);
    write_thresholds(16'($urandom_range(500, 6000)), 16'($urandom_range(2000, 30000)),
                     16'($urandom_range(0, 200)));
    random_phase(27, 27, 185, 1'b0);
    write_thresholds(16'($urandom_range(500, 6000)), 16'($urandom_range(2000, 30000)),
                     16'($urandom));
    random_phase(0, 0, 185, 1'b1);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
